// ===== rtl/core/tsfa_pkg.sv =====
// package for the touch sample filter with affine correction
// holds sizes, limits, register map, state codes and shared types
// no dependencies
`default_nettype none

package tsfa_pkg;

    localparam int BURST_SAMPLES = 10;
    localparam int COEF_SCALE    = 65536;
    localparam int COEF_SHIFT    = $clog2(COEF_SCALE);

    localparam int CODE_W  = 12;
    localparam int COEF_W  = 32;
    localparam int SCR_W   = 16;
    localparam int IDX_W   = $clog2(BURST_SAMPLES);
    localparam int CNT_W   = $clog2(BURST_SAMPLES + 1);
    localparam int PROD_W  = COEF_W + CODE_W + 1;
    localparam int ACC_W   = PROD_W + 3;
    localparam int ADDR_W  = 5;

    localparam int LOW_LIMIT   = 100;
    localparam int HIGH_LIMIT  = 4000;
    localparam int INVERT_BASE = 4096;
    localparam int RANK_LO     = 3;
    localparam int RANK_HI     = 4;
    localparam int TOL_RESET   = 20;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef t_code t_code_arr [BURST_SAMPLES];
    typedef t_idx  t_idx_arr  [BURST_SAMPLES];

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_xx;
        logic signed [COEF_W-1:0] coef_xy;
        logic signed [COEF_W-1:0] offset_x;
        logic signed [COEF_W-1:0] coef_yx;
        logic signed [COEF_W-1:0] coef_yy;
        logic signed [COEF_W-1:0] offset_y;
    } t_affine_cfg;

    typedef enum logic [2:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_COEF_YX  = 3'd3,
        REG_COEF_YY  = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_CALIB    = 3'd6,
        REG_PAIR_TOL = 3'd7
    } t_reg_addr;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EVAL = 7'b0000010,
        S_RANK = 7'b0000100,
        S_SEL  = 7'b0001000,
        S_CHK  = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_PUSH = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/tsfa_lane.sv =====
// rank lane: position of one buffered code in the stable sorted order
// depends on tsfa_pkg
`default_nettype none

module tsfa_lane (
    input  var tsfa_pkg::t_idx      i_idx,
    input  var tsfa_pkg::t_code_arr i_vals,
    output tsfa_pkg::t_idx          o_rank
);

    logic [tsfa_pkg::BURST_SAMPLES-1:0] w_below;
    tsfa_pkg::t_code                    w_own;

    always_comb begin
        w_own = i_vals[i_idx];
        for (int j = 0; j < tsfa_pkg::BURST_SAMPLES; j++) begin
            w_below[j] = (i_vals[j] < w_own) ||
                         ((tsfa_pkg::IDX_W'(j) < i_idx) && (i_vals[j] == w_own));
        end
    end

    assign o_rank = tsfa_pkg::IDX_W'($countones(w_below));

endmodule

`default_nettype wire

// ===== rtl/core/tsfa_merge.sv =====
// merge stage: picks ranks 3 and 4 per axis, checks spread, averages
// depends on tsfa_pkg
`default_nettype none

module tsfa_merge (
    input  var tsfa_pkg::t_code_arr i_x_vals,
    input  var tsfa_pkg::t_code_arr i_y_vals,
    input  var tsfa_pkg::t_idx_arr  i_x_rank,
    input  var tsfa_pkg::t_idx_arr  i_y_rank,
    input  var tsfa_pkg::t_code     i_tol,
    output tsfa_pkg::t_code         o_ax,
    output tsfa_pkg::t_code         o_ay,
    output logic                    o_ok
);

    tsfa_pkg::t_code                   w_x1, w_x2, w_y1, w_y2;
    logic [tsfa_pkg::CODE_W-1:0]       w_dx, w_dy;
    logic [tsfa_pkg::CODE_W:0]         w_sx, w_sy;

    always_comb begin
        w_x1 = '0;
        w_x2 = '0;
        w_y1 = '0;
        w_y2 = '0;
        for (int i = 0; i < tsfa_pkg::BURST_SAMPLES; i++) begin
            if (i_x_rank[i] == tsfa_pkg::IDX_W'(tsfa_pkg::RANK_LO)) w_x1 |= i_x_vals[i];
            if (i_x_rank[i] == tsfa_pkg::IDX_W'(tsfa_pkg::RANK_HI)) w_x2 |= i_x_vals[i];
            if (i_y_rank[i] == tsfa_pkg::IDX_W'(tsfa_pkg::RANK_LO)) w_y1 |= i_y_vals[i];
            if (i_y_rank[i] == tsfa_pkg::IDX_W'(tsfa_pkg::RANK_HI)) w_y2 |= i_y_vals[i];
        end
    end

    // sorted order means the higher rank is never below the lower one
    assign w_dx = w_x2 - w_x1;
    assign w_dy = w_y2 - w_y1;
    assign w_sx = {1'b0, w_x1} + {1'b0, w_x2};
    assign w_sy = {1'b0, w_y1} + {1'b0, w_y2};

    assign o_ok = (w_dx <= i_tol) && (w_dy <= i_tol);
    assign o_ax = w_sx[tsfa_pkg::CODE_W:1];
    assign o_ay = w_sy[tsfa_pkg::CODE_W:1];

endmodule

`default_nettype wire

// ===== rtl/core/tsfa_affine.sv =====
// affine correction: one shared multiplier stepped over four products,
// then truncating scale-down and 16-bit saturation; depends on tsfa_pkg
`default_nettype none

module tsfa_affine (
    input  var logic                  i_clk,
    input  var logic                  i_rst_n,
    input  var logic                  i_start,
    input  var tsfa_pkg::t_affine_cfg i_cfg,
    input  var tsfa_pkg::t_code       i_ax,
    input  var tsfa_pkg::t_code       i_ay,
    output logic                      o_done,
    output logic [tsfa_pkg::SCR_W-1:0] o_sx,
    output logic [tsfa_pkg::SCR_W-1:0] o_sy
);

    logic                                r_busy;
    logic [2:0]                          r_step;
    logic                                r_done;
    logic signed [tsfa_pkg::PROD_W-1:0]  r_prod;
    logic signed [tsfa_pkg::ACC_W-1:0]   r_acc_x;
    logic signed [tsfa_pkg::ACC_W-1:0]   r_acc_y;
    logic [tsfa_pkg::SCR_W-1:0]          r_sx;
    logic [tsfa_pkg::SCR_W-1:0]          r_sy;

    logic signed [tsfa_pkg::COEF_W-1:0]  w_coef;
    tsfa_pkg::t_code                     w_opnd;

    function automatic logic [tsfa_pkg::SCR_W-1:0] scale_sat(
        input logic signed [tsfa_pkg::ACC_W-1:0] acc
    );
        logic signed [tsfa_pkg::ACC_W-1:0] biased;
        logic signed [tsfa_pkg::ACC_W-1:0] q;
        logic [tsfa_pkg::SCR_W-1:0]        res;
        // bias negatives so the shift truncates toward zero
        biased = acc[tsfa_pkg::ACC_W-1] ?
                 acc + tsfa_pkg::ACC_W'(tsfa_pkg::COEF_SCALE - 1) : acc;
        q = biased >>> tsfa_pkg::COEF_SHIFT;
        if (q > tsfa_pkg::ACC_W'(32767)) begin
            res = 16'h7fff;
        end else if (q < -tsfa_pkg::ACC_W'(32768)) begin
            res = 16'h8000;
        end else begin
            res = q[tsfa_pkg::SCR_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        case (r_step)
            3'd0:    begin w_coef = i_cfg.coef_xx; w_opnd = i_ax; end
            3'd1:    begin w_coef = i_cfg.coef_xy; w_opnd = i_ay; end
            3'd2:    begin w_coef = i_cfg.coef_yx; w_opnd = i_ax; end
            default: begin w_coef = i_cfg.coef_yy; w_opnd = i_ay; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc_x <= tsfa_pkg::ACC_W'(i_cfg.offset_x);
            r_acc_y <= tsfa_pkg::ACC_W'(i_cfg.offset_y);
        end else if (r_busy) begin
            r_prod <= w_coef * $signed({1'b0, w_opnd});
            case (r_step)
                3'd1, 3'd2: r_acc_x <= r_acc_x + tsfa_pkg::ACC_W'(r_prod);
                3'd3, 3'd4: r_acc_y <= r_acc_y + tsfa_pkg::ACC_W'(r_prod);
                3'd5: begin
                    r_sx <= scale_sat(r_acc_x);
                    r_sy <= scale_sat(r_acc_y);
                end
                default: ;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sx   = r_sx;
    assign o_sy   = r_sy;

endmodule

`default_nettype wire

// ===== rtl/core/touch_sample_filter_affine.sv =====
// touch sample filter top level: stream ports, apb registers, sample buffer
// and sequencer; depends on tsfa_pkg, tsfa_lane, tsfa_merge, tsfa_affine
//
// input stream: one conversion per transaction, pen state in tuser and the
// raw x and y codes in tdata. output stream: pressed flag in tuser, the
// corrected screen x and y in tdata. a pen-up sample gives a release result,
// a valid sample is buffered, and every tenth buffered sample gives a
// position result when ranks 3 and 4 of each axis agree within tolerance.
// nothing is reported while the calibrated register is 0.
// timing: s_axis_tready is low after each accepted sample until the
// sequencer is back in idle. a release result goes from eval to push, a
// position result from the burst-closing sample through rank, merge,
// spread check and six multiplier steps to push; tready returns with it.
// a finished result sits in the output register until m_axis_tready takes it;
// the next sample is still accepted, and the sequencer holds a further result
// until the output register frees up.
// reset clears the sample count, the output valid and the registers
// (pair_tolerance to 20); buffer contents are not cleared.
`default_nettype none

module touch_sample_filter_affine (
    input  var logic                         i_clk,
    input  var logic                         i_rst_n,
    input  var logic                         s_axis_tvalid,
    output logic                             s_axis_tready,
    input  var logic [23:0]                  s_axis_tdata,  // x_code, y_code
    input  var logic                         s_axis_tuser,  // pen_down
    output logic                             m_axis_tvalid,
    input  var logic                         m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // screen_x, screen_y
    output logic                             m_axis_tuser,  // pressed
    input  var logic                         psel,
    input  var logic                         penable,
    input  var logic                         pwrite,
    input  var logic [tsfa_pkg::ADDR_W-1:0]  paddr,
    input  var logic [31:0]                  pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    tsfa_pkg::t_state      r_state, n_state;
    tsfa_pkg::t_affine_cfg r_cfg;
    logic                  r_calib;
    tsfa_pkg::t_code       r_tol;

    logic                  r_pen;
    tsfa_pkg::t_code       r_xc;
    tsfa_pkg::t_code       r_yc;
    tsfa_pkg::t_cnt        r_count;
    tsfa_pkg::t_code_arr   r_xbuf;
    tsfa_pkg::t_code_arr   r_ybuf;
    tsfa_pkg::t_idx_arr    r_rank_x;
    tsfa_pkg::t_idx_arr    r_rank_y;
    tsfa_pkg::t_code       r_ax;
    tsfa_pkg::t_code       r_ay;
    logic                  r_ok;

    logic                  r_res_pressed;
    logic [15:0]           r_res_x;
    logic [15:0]           r_res_y;
    logic                  r_out_valid;
    logic                  r_out_pressed;
    logic [15:0]           r_out_x;
    logic [15:0]           r_out_y;

    tsfa_pkg::t_idx_arr    w_rank_x;
    tsfa_pkg::t_idx_arr    w_rank_y;
    tsfa_pkg::t_code       w_ax;
    tsfa_pkg::t_code       w_ay;
    logic                  w_ok;
    logic                  w_aff_done;
    logic [15:0]           w_aff_x;
    logic [15:0]           w_aff_y;

    logic [12:0]           w_xinv;
    logic                  w_in_range;
    logic                  w_last;
    logic                  w_push;
    logic                  w_cfg_wr;
    tsfa_pkg::t_reg_addr   w_addr;

    // configuration port
    assign pready   = 1'b1;
    assign w_addr   = tsfa_pkg::t_reg_addr'(paddr[4:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= '0;
            r_calib <= 1'b0;
            r_tol   <= tsfa_pkg::CODE_W'(tsfa_pkg::TOL_RESET);
        end else if (w_cfg_wr) begin
            case (w_addr)
                tsfa_pkg::REG_COEF_XX:  r_cfg.coef_xx  <= pwdata;
                tsfa_pkg::REG_COEF_XY:  r_cfg.coef_xy  <= pwdata;
                tsfa_pkg::REG_OFFSET_X: r_cfg.offset_x <= pwdata;
                tsfa_pkg::REG_COEF_YX:  r_cfg.coef_yx  <= pwdata;
                tsfa_pkg::REG_COEF_YY:  r_cfg.coef_yy  <= pwdata;
                tsfa_pkg::REG_OFFSET_Y: r_cfg.offset_y <= pwdata;
                tsfa_pkg::REG_CALIB:    r_calib        <= pwdata[0];
                tsfa_pkg::REG_PAIR_TOL: r_tol          <= pwdata[tsfa_pkg::CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_addr)
            tsfa_pkg::REG_COEF_XX:  prdata = r_cfg.coef_xx;
            tsfa_pkg::REG_COEF_XY:  prdata = r_cfg.coef_xy;
            tsfa_pkg::REG_OFFSET_X: prdata = r_cfg.offset_x;
            tsfa_pkg::REG_COEF_YX:  prdata = r_cfg.coef_yx;
            tsfa_pkg::REG_COEF_YY:  prdata = r_cfg.coef_yy;
            tsfa_pkg::REG_OFFSET_Y: prdata = r_cfg.offset_y;
            tsfa_pkg::REG_CALIB:    prdata = {31'd0, r_calib};
            tsfa_pkg::REG_PAIR_TOL: prdata = {20'd0, r_tol};
            default:                prdata = '0;
        endcase
    end

    // sample qualification
    assign w_xinv     = 13'(tsfa_pkg::INVERT_BASE) - {1'b0, r_xc};
    assign w_in_range = (w_xinv > 13'(tsfa_pkg::LOW_LIMIT)) &&
                        (w_xinv < 13'(tsfa_pkg::HIGH_LIMIT)) &&
                        (r_yc > tsfa_pkg::CODE_W'(tsfa_pkg::LOW_LIMIT)) &&
                        (r_yc < tsfa_pkg::CODE_W'(tsfa_pkg::HIGH_LIMIT));
    assign w_last     = (r_count == tsfa_pkg::CNT_W'(tsfa_pkg::BURST_SAMPLES - 1));
    assign w_push     = (r_state == tsfa_pkg::S_PUSH) && (!r_out_valid || m_axis_tready);

    assign s_axis_tready = (r_state == tsfa_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            tsfa_pkg::S_IDLE: if (s_axis_tvalid) n_state = tsfa_pkg::S_EVAL;
            tsfa_pkg::S_EVAL: begin
                if (!r_calib) begin
                    n_state = tsfa_pkg::S_IDLE;
                end else if (!r_pen) begin
                    n_state = tsfa_pkg::S_PUSH;
                end else if (w_in_range && w_last) begin
                    n_state = tsfa_pkg::S_RANK;
                end else begin
                    n_state = tsfa_pkg::S_IDLE;
                end
            end
            tsfa_pkg::S_RANK: n_state = tsfa_pkg::S_SEL;
            tsfa_pkg::S_SEL:  n_state = tsfa_pkg::S_CHK;
            tsfa_pkg::S_CHK:  n_state = r_ok ? tsfa_pkg::S_MUL : tsfa_pkg::S_IDLE;
            tsfa_pkg::S_MUL:  if (w_aff_done) n_state = tsfa_pkg::S_PUSH;
            tsfa_pkg::S_PUSH: if (w_push) n_state = tsfa_pkg::S_IDLE;
            default:          n_state = tsfa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsfa_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tsfa_pkg::S_EVAL) begin
                if (!r_calib || !r_pen) begin
                    r_count <= '0;
                end else if (w_in_range) begin
                    r_count <= w_last ? '0 : r_count + tsfa_pkg::CNT_W'(1);
                end
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_pen <= s_axis_tuser;
            r_xc  <= s_axis_tdata[11:0];
            r_yc  <= s_axis_tdata[23:12];
        end
        if ((r_state == tsfa_pkg::S_EVAL) && r_calib && r_pen && w_in_range) begin
            r_xbuf[r_count[tsfa_pkg::IDX_W-1:0]] <= w_xinv[tsfa_pkg::CODE_W-1:0];
            r_ybuf[r_count[tsfa_pkg::IDX_W-1:0]] <= r_yc;
        end
        if (r_state == tsfa_pkg::S_RANK) begin
            r_rank_x <= w_rank_x;
            r_rank_y <= w_rank_y;
        end
        if (r_state == tsfa_pkg::S_SEL) begin
            r_ax <= w_ax;
            r_ay <= w_ay;
            r_ok <= w_ok;
        end
        if (r_state == tsfa_pkg::S_EVAL) begin
            r_res_pressed <= 1'b0;
            r_res_x       <= '0;
            r_res_y       <= '0;
        end else if ((r_state == tsfa_pkg::S_MUL) && w_aff_done) begin
            r_res_pressed <= 1'b1;
            r_res_x       <= w_aff_x;
            r_res_y       <= w_aff_y;
        end
        if (w_push) begin
            r_out_pressed <= r_res_pressed;
            r_out_x       <= r_res_x;
            r_out_y       <= r_res_y;
        end
    end

    for (genvar g = 0; g < tsfa_pkg::BURST_SAMPLES; g++) begin : g_lane
        tsfa_lane u_lane_x (
            .i_idx  (tsfa_pkg::IDX_W'(g)),
            .i_vals (r_xbuf),
            .o_rank (w_rank_x[g])
        );
        tsfa_lane u_lane_y (
            .i_idx  (tsfa_pkg::IDX_W'(g)),
            .i_vals (r_ybuf),
            .o_rank (w_rank_y[g])
        );
    end

    tsfa_merge u_merge (
        .i_x_vals (r_xbuf),
        .i_y_vals (r_ybuf),
        .i_x_rank (r_rank_x),
        .i_y_rank (r_rank_y),
        .i_tol    (r_tol),
        .o_ax     (w_ax),
        .o_ay     (w_ay),
        .o_ok     (w_ok)
    );

    tsfa_affine u_affine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == tsfa_pkg::S_CHK) && r_ok),
        .i_cfg   (r_cfg),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .o_done  (w_aff_done),
        .o_sx    (w_aff_x),
        .o_sy    (w_aff_y)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_pressed;
    assign m_axis_tdata  = {r_out_y, r_out_x};

endmodule

`default_nettype wire
